FILE: src/smpq_pkg.sv
// Shared constants, codes and types of the sorted minimum priority queue.
package smpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 5;

    typedef logic [1:0]              op_t;
    typedef logic [1:0]              stat_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [OCC_W-1:0]        occ_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    localparam op_t OP_ENQUEUE = 2'd0;
    localparam op_t OP_DEQUEUE = 2'd1;
    localparam op_t OP_PEEK    = 2'd2;

    localparam stat_t ST_OK    = 2'd0;
    localparam stat_t ST_EMPTY = 2'd1;
    localparam stat_t ST_FULL  = 2'd2;

    localparam val_t EMPTY_VALUE = -32'sd1;
    localparam val_t NULL_VALUE  = 32'sd0;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

FILE: src/smpq_req_if.sv
// Request channel: operation and value words with valid/ready handshake.
interface smpq_req_if;
    import smpq_pkg::*;

    logic  valid;
    logic  ready;
    op_t   operation;
    val_t  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

FILE: src/smpq_rsp_if.sv
// Response channel: result value, status and occupancy with valid/ready handshake.
interface smpq_rsp_if;
    import smpq_pkg::*;

    logic  valid;
    logic  ready;
    val_t  result_value;
    stat_t status;
    occ_t  occupancy;

    modport source (output valid, output result_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_value, input status, input occupancy,
                    output ready);
endinterface

FILE: src/sorted_min_priority_queue.sv
// Top level of the sorted minimum-first priority queue.
// Holds up to CAPACITY (16) signed 32-bit values in ascending order.
// Request channel req carries an operation (enqueue, dequeue, peek) and a
// value; every request word yields exactly one response word on rsp with
// result_value, status (ok, empty, full) and the occupancy after the step.
// Equal values leave in arrival order. A dequeue or peek on an empty queue
// returns -1 with status empty; an enqueue into a full queue is dropped.
// A request word is captured into the operation and value registers in the
// idle state; the execute state runs the whole insert or shift of the
// list at once, all cells comparing in parallel, and loads the result into
// the output register. No new word is taken until that execution is done.
// The response sits in an output register, so the next request is accepted
// while the previous response waits; if the receiver stalls, execution of
// that next request waits until the pending response is taken.
// Reset clears the entry count and all handshake state; list contents are
// not cleared and are never read before they are written.
module sorted_min_priority_queue (
    input logic        clk,
    input logic        rst_n,
    smpq_req_if.sink   req,
    smpq_rsp_if.source rsp
);
    import smpq_pkg::*;

    cmd_t cmd;

    smpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    smpq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_operation (req.operation),
        .in_value     (req.value),
        .result_value (rsp.result_value),
        .status       (rsp.status),
        .occupancy    (rsp.occupancy)
    );

endmodule

FILE: src/smpq_datapath.sv
// Datapath: sorted shift-register list, entry count and the result register.
module smpq_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  smpq_pkg::cmd_t    cmd,
    input  smpq_pkg::op_t     in_operation,
    input  smpq_pkg::val_t    in_value,
    output smpq_pkg::val_t    result_value,
    output smpq_pkg::stat_t   status,
    output smpq_pkg::occ_t    occupancy
);
    import smpq_pkg::*;

    op_t   op_reg;
    val_t  val_reg;
    val_t  entry_reg [CAPACITY];
    val_t  entry_next [CAPACITY];
    cnt_t  count_reg;
    cnt_t  count_next;
    val_t  result_reg;
    val_t  result_next;
    stat_t status_reg;
    stat_t status_next;
    occ_t  occ_reg;
    logic  [CAPACITY-1:0] le;
    logic  full;
    logic  empty;

    assign full  = (count_reg == cnt_t'(CAPACITY));
    assign empty = (count_reg == '0);

    // Cell i holds a live value not greater than the incoming one
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            le[i] = (cnt_t'(i) < count_reg) && (entry_reg[i] <= val_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        count_next  = count_reg;
        result_next = NULL_VALUE;
        status_next = ST_OK;
        case (op_reg) inside
            OP_ENQUEUE:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // keep the prefix, drop the new word at the boundary, shift the rest up
                    entry_next[0] = le[0] ? entry_reg[0] : val_reg;
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        if (le[i])
                        begin
                            entry_next[i] = entry_reg[i];
                        end
                        else if (le[i-1])
                        begin
                            entry_next[i] = val_reg;
                        end
                        else
                        begin
                            entry_next[i] = entry_reg[i-1];
                        end
                    end
                    count_next = count_reg + cnt_t'(1);
                end
            end
            OP_DEQUEUE, OP_PEEK:
            begin
                if (empty)
                begin
                    result_next = EMPTY_VALUE;
                    status_next = ST_EMPTY;
                end
                else
                begin
                    result_next = entry_reg[0];
                    if (op_reg == OP_DEQUEUE)
                    begin
                        // advance every cell but the last toward the head
                        for (int i = 0; i < CAPACITY - 1; i++)
                        begin
                            entry_next[i] = entry_reg[i+1];
                        end
                        count_next = count_reg - cnt_t'(1);
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_operation;
            val_reg <= in_value;
        end
        if (cmd.execute)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
            result_reg <= result_next;
            status_reg <= status_next;
            occ_reg    <= occ_t'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    assign result_value = result_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && op_reg == OP_ENQUEUE && full) |=> $stable(count_reg))
        else $error("dropped enqueue changed the count");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && op_reg == OP_DEQUEUE && !empty) |=>
        (count_reg == $past(count_reg) - cnt_t'(1)))
        else $error("dequeue did not remove one entry");

endmodule

FILE: src/smpq_ctrl.sv
// Controller: accepts a request, runs it once the response register is free.
module smpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output smpq_pkg::cmd_t cmd
);
    import smpq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_EXEC:
            begin
                cmd.execute = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // hold the response word until taken, reload on execute
    always_comb
    begin
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

    a_exec_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> rsp_valid)
        else $error("executed word not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !cmd.execute)
        else $error("pending response overwritten");

endmodule
